// ===== design/ilha_pkg.sv =====
package ilha_pkg;

  // heap geometry
  localparam int HEAP_BYTES  = 65536;
  localparam int ALIGN_BYTES = 16;
  localparam int TAG_BYTES   = ALIGN_BYTES / 2;
  localparam int MIN_CHUNK   = 2 * TAG_BYTES;
  localparam int TAG_DEPTH   = HEAP_BYTES / TAG_BYTES;
  localparam int TAG_SHIFT   = $clog2(TAG_BYTES);
  localparam int IDX_W       = $clog2(TAG_DEPTH);
  localparam int SIZE_W      = $clog2(HEAP_BYTES) + 1;
  localparam int SUM_W       = SIZE_W + 1;

  // operation codes
  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_RESIZE  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] payload_address;
    logic [15:0] request_bytes;
  } req_t;

  typedef struct packed {
    logic [15:0] result_address;
    logic [1:0]  status;
    logic [15:0] copy_source;
    logic [15:0] copy_bytes;
  } rsp_t;

  // datapath micro-operations
  typedef enum logic [4:0] {
    C_NOP,
    C_ACCEPT,
    C_WALK_INIT,
    C_RD_WK,
    C_WK_CAP,
    C_WK_NEXT,
    C_MK_FOUND,
    C_GROW,
    C_W0,
    C_W1,
    C_W2,
    C_W3,
    C_SET_OK_WK,
    C_SET_OK_P,
    C_SET_OOM,
    C_SET_COPY,
    C_CH_INIT,
    C_RD_CH,
    C_CH_CAP,
    C_MK_CH_FREE,
    C_NX,
    C_RD_NX,
    C_NX_CAP,
    C_MERGE_NX,
    C_RD_PF,
    C_PF_CAP,
    C_RD_PA,
    C_PA_CAP,
    C_MERGE_PA,
    C_MK_SHRINK,
    C_MK_ABSORB,
    C_OUT_LOAD
  } cmd_t;

  typedef enum logic [5:0] {
    S_IDLE,
    S_DISPATCH,
    S_WALK_INIT,
    S_WALK_CHK,
    S_WALK_CAP,
    S_WALK_TEST,
    S_GROW,
    S_A_END,
    S_COPY,
    S_W0,
    S_W1,
    S_W2,
    S_W3,
    S_F_CH,
    S_F_RD,
    S_F_CAP,
    S_F_MK,
    S_F_NX,
    S_F_NRD,
    S_F_NCAP,
    S_F_NTEST,
    S_F_PV,
    S_F_PCAP,
    S_F_PTEST,
    S_F_PACAP,
    S_F_PATEST,
    S_R_CH,
    S_R_RD,
    S_R_CAP,
    S_R_TEST,
    S_R_SHW,
    S_R_NRD,
    S_R_NCAP,
    S_R_NTEST,
    S_R_OK,
    S_OUT
  } state_t;

  // datapath flags seen by the controller
  typedef struct packed {
    logic [1:0] op;
    logic       p_zero;
    logic       bytes_zero;
    logic       wk_zero;
    logic       wk_fit;
    logic       grow_ok;
    logic       mk_split;
    logic       nx_ok;
    logic       nu;
    logic       absorb_fit;
    logic       shrink;
    logic       ch_gt_tag;
    logic       pf_ok;
    logic       pu;
    logic       out_free;
  } stat_t;

endpackage

// ===== design/implicit_list_heap_allocator.sv =====
// channel  direction  word     handshake
// req      in         req_t    req_valid / req_stall
// rsp      out        rsp_t    rsp_valid / rsp_stall
//
// One request word at a time; req_stall is high from accept until the result
// is loaded into the output register. Allocation walks the chunk list with one
// tag read per chunk, then sets up, writes tags and loads the result; release
// reads and writes tags likewise; a relocating resize is both plus in-place
// checks and copy setup.
// Synchronous reset sets the heap top to 8; the tag store is not cleared.
// A stalled result holds in the output register while the next request runs.
module implicit_list_heap_allocator (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  ilha_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output ilha_pkg::rsp_t rsp
);

  ilha_pkg::cmd_t  cmd;
  ilha_pkg::stat_t stat;

  // sequencer
  ilha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (req_stall)
  );

  // tag store, working registers and result register
  ilha_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== design/ilha_dpath.sv =====
module ilha_dpath (
  input  logic            clk,
  input  logic            rst,
  input  ilha_pkg::req_t  req,
  input  ilha_pkg::cmd_t  cmd,
  output ilha_pkg::stat_t stat,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output ilha_pkg::rsp_t  rsp
);

  localparam int SW = ilha_pkg::SIZE_W;
  localparam int AW = ilha_pkg::SUM_W;
  localparam int IDX_W_HI = ilha_pkg::IDX_W + ilha_pkg::TAG_SHIFT - 1;
  localparam logic [SW-1:0] SZ_TAG  = SW'(ilha_pkg::TAG_BYTES);
  localparam logic [SW-1:0] SZ_MIN  = SW'(ilha_pkg::MIN_CHUNK);
  localparam logic [SW-1:0] SZ_ALGN = SW'(ilha_pkg::ALIGN_BYTES - 1);
  localparam logic [AW-1:0] A_HEAP  = AW'(ilha_pkg::HEAP_BYTES);
  localparam logic [AW-1:0] A_TAG   = AW'(ilha_pkg::TAG_BYTES);

  // remainder after carving need out of t is a whole aligned chunk
  function automatic logic split_of(input logic [SW-1:0] t, input logic [SW-1:0] nd);
    logic [SW-1:0] r;
    r = t - nd;
    return (t >= nd) && (r >= SZ_MIN) && ((r & SZ_ALGN) == '0);
  endfunction

  logic [1:0]    op;
  logic [SW-1:0] pv, need, top;
  logic          bytes_zero;
  logic [SW-1:0] wk, ws, ch, cs, nx, ns, pa, ps, mk_h, mk_t;
  logic          wu, cu, nu, pu, mk_u, mk_split;
  logic [15:0]   res_addr, res_csrc, res_cbytes;
  logic [1:0]    res_st;

  logic [SW-1:0] mem [ilha_pkg::TAG_DEPTH];
  logic [SW-1:0] q;
  logic          q_oob;

  logic [SW-1:0] rdata, rsize, fs, rem, old_pay, new_pay, sum_cn;
  logic          rused;
  logic [AW-1:0] rd_a, wr_a;
  logic [SW-1:0] wr_d;
  logic          rd_en, wr_en;
  logic [AW-1:0] pin_end;
  logic          pin_ok;
  logic [SW-1:0] need_in;

  assign rdata  = q_oob ? '0 : q;
  assign rsize  = {rdata[SW-1:1], 1'b0};
  assign rused  = rdata[0];
  assign fs     = mk_split ? need : mk_t;
  assign rem    = mk_t - need;
  assign sum_cn = cs + ns;

  // input normalization and chunk size for the request
  assign pin_end = AW'(req.payload_address) + A_TAG;
  assign pin_ok  = (req.payload_address >= 16'(ilha_pkg::MIN_CHUNK))
                   && (pin_end <= AW'(top));
  assign need_in = ((SW'(req.request_bytes) + SZ_ALGN) & ~SZ_ALGN) + SZ_MIN;

  // payload sizes for the relocation copy
  assign old_pay = (cs >= SZ_MIN) ? cs - SZ_MIN : '0;
  assign new_pay = need - SZ_MIN;

  // tag store address and data selection
  always_comb begin
    rd_en = 1'b0;
    wr_en = 1'b0;
    rd_a  = '0;
    wr_a  = '0;
    wr_d  = '0;
    case (cmd)
      ilha_pkg::C_RD_WK: begin
        rd_en = 1'b1;
        rd_a  = AW'(wk);
      end
      ilha_pkg::C_RD_CH: begin
        rd_en = 1'b1;
        rd_a  = AW'(ch);
      end
      ilha_pkg::C_RD_NX: begin
        rd_en = 1'b1;
        rd_a  = AW'(nx);
      end
      ilha_pkg::C_RD_PF: begin
        rd_en = 1'b1;
        rd_a  = AW'(ch) - A_TAG;
      end
      ilha_pkg::C_RD_PA: begin
        rd_en = 1'b1;
        rd_a  = AW'(pa);
      end
      ilha_pkg::C_W0: begin
        wr_en = 1'b1;
        wr_a  = AW'(mk_h);
        wr_d  = fs | SW'(mk_u);
      end
      ilha_pkg::C_W1: begin
        wr_en = 1'b1;
        wr_a  = AW'(mk_h) + AW'(fs) - A_TAG;
        wr_d  = fs | SW'(mk_u);
      end
      ilha_pkg::C_W2: begin
        wr_en = 1'b1;
        wr_a  = AW'(mk_h) + AW'(need);
        wr_d  = rem;
      end
      ilha_pkg::C_W3: begin
        wr_en = 1'b1;
        wr_a  = AW'(mk_h) + AW'(mk_t) - A_TAG;
        wr_d  = rem;
      end
      default: begin
      end
    endcase
  end

  // tag store, one read or one write a cycle, registered read data
  always_ff @(posedge clk) begin
    if (wr_en && (wr_a < A_HEAP)) begin
      mem[wr_a[IDX_W_HI:ilha_pkg::TAG_SHIFT]] <= wr_d;
    end
    if (rd_en) begin
      q     <= mem[rd_a[IDX_W_HI:ilha_pkg::TAG_SHIFT]];
      q_oob <= !(rd_a < A_HEAP);
    end
  end

  // heap top
  always_ff @(posedge clk) begin
    if (rst) begin
      top <= SZ_TAG;
    end else if (cmd == ilha_pkg::C_GROW) begin
      top <= top + need;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd)
      ilha_pkg::C_ACCEPT: begin
        op         <= req.operation;
        pv         <= pin_ok ? SW'(req.payload_address) : '0;
        bytes_zero <= (req.request_bytes == '0);
        need       <= need_in;
        res_addr   <= '0;
        res_st     <= ilha_pkg::ST_NULL;
        res_csrc   <= '0;
        res_cbytes <= '0;
      end
      ilha_pkg::C_WALK_INIT: wk <= (top > SZ_TAG) ? SZ_TAG : '0;
      ilha_pkg::C_WK_CAP: begin
        ws <= rsize;
        wu <= rused;
      end
      ilha_pkg::C_WK_NEXT: begin
        if ((ws < SZ_MIN) || ((AW'(wk) + AW'(ws)) >= AW'(top))) begin
          wk <= '0;
        end else begin
          wk <= wk + ws;
        end
      end
      ilha_pkg::C_MK_FOUND: begin
        mk_h     <= wk;
        mk_t     <= ws;
        mk_u     <= 1'b1;
        mk_split <= split_of(ws, need);
      end
      ilha_pkg::C_GROW: begin
        mk_h     <= top;
        mk_t     <= need;
        mk_u     <= 1'b1;
        mk_split <= 1'b0;
        wk       <= top;
      end
      ilha_pkg::C_SET_OK_WK: begin
        res_addr <= 16'(wk + SZ_TAG);
        res_st   <= ilha_pkg::ST_OK;
      end
      ilha_pkg::C_SET_OK_P: begin
        res_addr <= pv[15:0];
        res_st   <= ilha_pkg::ST_OK;
      end
      ilha_pkg::C_SET_OOM: begin
        res_addr <= '0;
        res_st   <= ilha_pkg::ST_OOM;
      end
      ilha_pkg::C_SET_COPY: begin
        res_csrc   <= pv[15:0];
        res_cbytes <= 16'((old_pay < new_pay) ? old_pay : new_pay);
      end
      ilha_pkg::C_CH_INIT: ch <= pv - SZ_TAG;
      ilha_pkg::C_CH_CAP: begin
        cs <= rsize;
        cu <= rused;
      end
      ilha_pkg::C_MK_CH_FREE: begin
        mk_h     <= ch;
        mk_t     <= cs;
        mk_u     <= 1'b0;
        mk_split <= 1'b0;
      end
      ilha_pkg::C_NX: nx <= ch + cs;
      ilha_pkg::C_NX_CAP: begin
        ns <= rsize;
        nu <= rused;
      end
      ilha_pkg::C_MERGE_NX: begin
        cs       <= sum_cn;
        mk_h     <= ch;
        mk_t     <= sum_cn;
        mk_u     <= 1'b0;
        mk_split <= 1'b0;
      end
      ilha_pkg::C_PF_CAP: begin
        ps <= rsize;
        pa <= ch - rsize;
      end
      ilha_pkg::C_PA_CAP: begin
        ps <= rsize;
        pu <= rused;
      end
      ilha_pkg::C_MERGE_PA: begin
        mk_h     <= pa;
        mk_t     <= ps + cs;
        mk_u     <= 1'b0;
        mk_split <= 1'b0;
      end
      ilha_pkg::C_MK_SHRINK: begin
        mk_h     <= ch;
        mk_t     <= cs;
        mk_u     <= cu;
        mk_split <= split_of(cs, need);
      end
      ilha_pkg::C_MK_ABSORB: begin
        mk_h     <= ch;
        mk_t     <= sum_cn;
        mk_u     <= 1'b1;
        mk_split <= split_of(sum_cn, need);
      end
      default: begin
      end
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd == ilha_pkg::C_OUT_LOAD) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == ilha_pkg::C_OUT_LOAD) begin
      rsp.result_address <= res_addr;
      rsp.status         <= res_st;
      rsp.copy_source    <= res_csrc;
      rsp.copy_bytes     <= res_cbytes;
    end
  end

  // flags for the controller
  always_comb begin
    stat.op         = op;
    stat.p_zero     = (pv == '0);
    stat.bytes_zero = bytes_zero;
    stat.wk_zero    = (wk == '0);
    stat.wk_fit     = !wu && (ws >= need);
    stat.grow_ok    = (AW'(top) <= A_HEAP) && ((AW'(top) + AW'(need)) <= A_HEAP);
    stat.mk_split   = mk_split;
    stat.nx_ok      = (cs >= SZ_MIN) && ((AW'(ch) + AW'(cs)) < AW'(top));
    stat.nu         = nu;
    stat.absorb_fit = !nu && ((AW'(cs) + AW'(ns)) >= AW'(need));
    stat.shrink     = (cs >= need);
    stat.ch_gt_tag  = (ch > SZ_TAG);
    stat.pf_ok      = (ps >= SZ_MIN) && (ps <= ch - SZ_TAG);
    stat.pu         = pu;
    stat.out_free   = !rsp_valid || !rsp_stall;
  end

endmodule

// ===== design/ilha_ctrl.sv =====
module ilha_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  ilha_pkg::stat_t stat,
  output ilha_pkg::cmd_t  cmd,
  output logic            busy
);

  ilha_pkg::state_t state, state_next, ret, ret_next;
  logic             reloc, reloc_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ilha_pkg::S_IDLE;
      ret   <= ilha_pkg::S_IDLE;
      reloc <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      reloc <= reloc_next;
    end
  end

  assign busy = (state != ilha_pkg::S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    ret_next   = ret;
    reloc_next = reloc;
    cmd        = ilha_pkg::C_NOP;
    case (state)
      ilha_pkg::S_IDLE: begin
        if (req_valid) begin
          cmd        = ilha_pkg::C_ACCEPT;
          reloc_next = 1'b0;
          state_next = ilha_pkg::S_DISPATCH;
        end
      end
      ilha_pkg::S_DISPATCH: begin
        case (stat.op)
          ilha_pkg::OP_ALLOC: begin
            state_next = stat.bytes_zero ? ilha_pkg::S_OUT : ilha_pkg::S_WALK_INIT;
          end
          ilha_pkg::OP_RELEASE: begin
            state_next = stat.p_zero ? ilha_pkg::S_OUT : ilha_pkg::S_F_CH;
          end
          ilha_pkg::OP_RESIZE: begin
            if (stat.p_zero) begin
              state_next = stat.bytes_zero ? ilha_pkg::S_OUT : ilha_pkg::S_WALK_INIT;
            end else if (stat.bytes_zero) begin
              state_next = ilha_pkg::S_F_CH;
            end else begin
              state_next = ilha_pkg::S_R_CH;
            end
          end
          default: state_next = ilha_pkg::S_OUT;
        endcase
      end
      // first-fit walk
      ilha_pkg::S_WALK_INIT: begin
        cmd        = ilha_pkg::C_WALK_INIT;
        state_next = ilha_pkg::S_WALK_CHK;
      end
      ilha_pkg::S_WALK_CHK: begin
        if (stat.wk_zero) begin
          state_next = ilha_pkg::S_GROW;
        end else begin
          cmd        = ilha_pkg::C_RD_WK;
          state_next = ilha_pkg::S_WALK_CAP;
        end
      end
      ilha_pkg::S_WALK_CAP: begin
        cmd        = ilha_pkg::C_WK_CAP;
        state_next = ilha_pkg::S_WALK_TEST;
      end
      ilha_pkg::S_WALK_TEST: begin
        if (stat.wk_fit) begin
          cmd        = ilha_pkg::C_MK_FOUND;
          ret_next   = ilha_pkg::S_A_END;
          state_next = ilha_pkg::S_W0;
        end else begin
          cmd        = ilha_pkg::C_WK_NEXT;
          state_next = ilha_pkg::S_WALK_CHK;
        end
      end
      ilha_pkg::S_GROW: begin
        if (stat.grow_ok) begin
          cmd        = ilha_pkg::C_GROW;
          ret_next   = ilha_pkg::S_A_END;
          state_next = ilha_pkg::S_W0;
        end else begin
          cmd        = ilha_pkg::C_SET_OOM;
          state_next = ilha_pkg::S_OUT;
        end
      end
      ilha_pkg::S_A_END: begin
        cmd        = ilha_pkg::C_SET_OK_WK;
        state_next = reloc ? ilha_pkg::S_COPY : ilha_pkg::S_OUT;
      end
      ilha_pkg::S_COPY: begin
        cmd        = ilha_pkg::C_SET_COPY;
        state_next = ilha_pkg::S_F_CH;
      end
      // shared tag write sequence
      ilha_pkg::S_W0: begin
        cmd        = ilha_pkg::C_W0;
        state_next = ilha_pkg::S_W1;
      end
      ilha_pkg::S_W1: begin
        cmd        = ilha_pkg::C_W1;
        state_next = stat.mk_split ? ilha_pkg::S_W2 : ret;
      end
      ilha_pkg::S_W2: begin
        cmd        = ilha_pkg::C_W2;
        state_next = ilha_pkg::S_W3;
      end
      ilha_pkg::S_W3: begin
        cmd        = ilha_pkg::C_W3;
        state_next = ret;
      end
      // release with coalescing
      ilha_pkg::S_F_CH: begin
        cmd        = ilha_pkg::C_CH_INIT;
        state_next = ilha_pkg::S_F_RD;
      end
      ilha_pkg::S_F_RD: begin
        cmd        = ilha_pkg::C_RD_CH;
        state_next = ilha_pkg::S_F_CAP;
      end
      ilha_pkg::S_F_CAP: begin
        cmd        = ilha_pkg::C_CH_CAP;
        state_next = ilha_pkg::S_F_MK;
      end
      ilha_pkg::S_F_MK: begin
        cmd        = ilha_pkg::C_MK_CH_FREE;
        ret_next   = ilha_pkg::S_F_NX;
        state_next = ilha_pkg::S_W0;
      end
      ilha_pkg::S_F_NX: begin
        if (stat.nx_ok) begin
          cmd        = ilha_pkg::C_NX;
          state_next = ilha_pkg::S_F_NRD;
        end else begin
          state_next = ilha_pkg::S_F_PV;
        end
      end
      ilha_pkg::S_F_NRD: begin
        cmd        = ilha_pkg::C_RD_NX;
        state_next = ilha_pkg::S_F_NCAP;
      end
      ilha_pkg::S_F_NCAP: begin
        cmd        = ilha_pkg::C_NX_CAP;
        state_next = ilha_pkg::S_F_NTEST;
      end
      ilha_pkg::S_F_NTEST: begin
        if (!stat.nu) begin
          cmd        = ilha_pkg::C_MERGE_NX;
          ret_next   = ilha_pkg::S_F_PV;
          state_next = ilha_pkg::S_W0;
        end else begin
          state_next = ilha_pkg::S_F_PV;
        end
      end
      ilha_pkg::S_F_PV: begin
        if (stat.ch_gt_tag) begin
          cmd        = ilha_pkg::C_RD_PF;
          state_next = ilha_pkg::S_F_PCAP;
        end else begin
          state_next = ilha_pkg::S_OUT;
        end
      end
      ilha_pkg::S_F_PCAP: begin
        cmd        = ilha_pkg::C_PF_CAP;
        state_next = ilha_pkg::S_F_PTEST;
      end
      ilha_pkg::S_F_PTEST: begin
        if (stat.pf_ok) begin
          cmd        = ilha_pkg::C_RD_PA;
          state_next = ilha_pkg::S_F_PACAP;
        end else begin
          state_next = ilha_pkg::S_OUT;
        end
      end
      ilha_pkg::S_F_PACAP: begin
        cmd        = ilha_pkg::C_PA_CAP;
        state_next = ilha_pkg::S_F_PATEST;
      end
      ilha_pkg::S_F_PATEST: begin
        if (!stat.pu) begin
          cmd        = ilha_pkg::C_MERGE_PA;
          ret_next   = ilha_pkg::S_OUT;
          state_next = ilha_pkg::S_W0;
        end else begin
          state_next = ilha_pkg::S_OUT;
        end
      end
      // resize in place or relocate
      ilha_pkg::S_R_CH: begin
        cmd        = ilha_pkg::C_CH_INIT;
        state_next = ilha_pkg::S_R_RD;
      end
      ilha_pkg::S_R_RD: begin
        cmd        = ilha_pkg::C_RD_CH;
        state_next = ilha_pkg::S_R_CAP;
      end
      ilha_pkg::S_R_CAP: begin
        cmd        = ilha_pkg::C_CH_CAP;
        state_next = ilha_pkg::S_R_TEST;
      end
      ilha_pkg::S_R_TEST: begin
        if (stat.shrink) begin
          cmd        = ilha_pkg::C_MK_SHRINK;
          state_next = ilha_pkg::S_R_SHW;
        end else if (stat.nx_ok) begin
          cmd        = ilha_pkg::C_NX;
          state_next = ilha_pkg::S_R_NRD;
        end else begin
          reloc_next = 1'b1;
          state_next = ilha_pkg::S_WALK_INIT;
        end
      end
      ilha_pkg::S_R_SHW: begin
        if (stat.mk_split) begin
          ret_next   = ilha_pkg::S_R_OK;
          state_next = ilha_pkg::S_W0;
        end else begin
          state_next = ilha_pkg::S_R_OK;
        end
      end
      ilha_pkg::S_R_NRD: begin
        cmd        = ilha_pkg::C_RD_NX;
        state_next = ilha_pkg::S_R_NCAP;
      end
      ilha_pkg::S_R_NCAP: begin
        cmd        = ilha_pkg::C_NX_CAP;
        state_next = ilha_pkg::S_R_NTEST;
      end
      ilha_pkg::S_R_NTEST: begin
        if (stat.absorb_fit) begin
          cmd        = ilha_pkg::C_MK_ABSORB;
          ret_next   = ilha_pkg::S_R_OK;
          state_next = ilha_pkg::S_W0;
        end else begin
          reloc_next = 1'b1;
          state_next = ilha_pkg::S_WALK_INIT;
        end
      end
      ilha_pkg::S_R_OK: begin
        cmd        = ilha_pkg::C_SET_OK_P;
        state_next = ilha_pkg::S_OUT;
      end
      // hand the result word to the output register
      ilha_pkg::S_OUT: begin
        if (stat.out_free) begin
          cmd        = ilha_pkg::C_OUT_LOAD;
          state_next = ilha_pkg::S_IDLE;
        end
      end
      default: state_next = ilha_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== test/tb.sv =====
module tb;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  ilha_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  ilha_pkg::rsp_t rsp;

  implicit_list_heap_allocator dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall),
    .req(req), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // predictor state: one tag per 8-byte heap word
  logic [16:0] tags [ilha_pkg::TAG_DEPTH];
  logic [16:0] top;

  ilha_pkg::req_t pending [$];
  ilha_pkg::rsp_t expected [$];
  logic [15:0] live [$];
  int errors = 0;
  int idle_cycles = 0;
  bit req_taken;
  int req_gap;
  int rsp_gap;

  function automatic logic [16:0] tag_get(logic [16:0] a);
    if ((a >> ilha_pkg::TAG_SHIFT) < ilha_pkg::TAG_DEPTH) return tags[a >> ilha_pkg::TAG_SHIFT];
    return '0;
  endfunction

  function automatic void tag_put(logic [16:0] a, logic [16:0] v);
    if ((a >> ilha_pkg::TAG_SHIFT) < ilha_pkg::TAG_DEPTH) tags[a >> ilha_pkg::TAG_SHIFT] = v;
  endfunction

  function automatic logic [16:0] size_of(logic [16:0] h);
    return tag_get(h) & ~17'd1;
  endfunction

  function automatic bit busy(logic [16:0] h);
    return (tag_get(h) & 17'd1) != 17'd0;
  endfunction

  function automatic void mark(logic [16:0] h, logic [16:0] sz, bit a);
    tag_put(h, sz | 17'(a));
    tag_put(17'(h + sz - ilha_pkg::TAG_BYTES), sz | 17'(a));
  endfunction

  function automatic logic [16:0] next_chunk(logic [16:0] h);
    logic [16:0] sz;
    sz = size_of(h);
    if (sz < ilha_pkg::MIN_CHUNK || 32'(h) + sz >= top) return '0;
    return h + sz;
  endfunction

  function automatic logic [16:0] prev_chunk(logic [16:0] h);
    logic [16:0] ps;
    if (h <= ilha_pkg::TAG_BYTES) return '0;
    ps = size_of(17'(h - ilha_pkg::TAG_BYTES));
    if (ps < ilha_pkg::MIN_CHUNK || ps > h - ilha_pkg::TAG_BYTES) return '0;
    return h - ps;
  endfunction

  function automatic void carve(logic [16:0] h, logic [16:0] need);
    logic [16:0] orig;
    logic [16:0] rem;
    orig = size_of(h);
    if (orig < need) return;
    rem = orig - need;
    if (rem < ilha_pkg::MIN_CHUNK || rem % ilha_pkg::ALIGN_BYTES != 0) return;
    mark(h, need, busy(h));
    mark(h + need, rem, 1'b0);
  endfunction

  function automatic logic [16:0] chunk_bytes(logic [15:0] b);
    return 17'(((17'(b) + ilha_pkg::ALIGN_BYTES - 1) & ~17'(ilha_pkg::ALIGN_BYTES - 1))
               + ilha_pkg::MIN_CHUNK);
  endfunction

  function automatic logic [1:0] heap_alloc(logic [15:0] b, output logic [15:0] addr);
    logic [16:0] need;
    logic [16:0] h;
    bit hit;
    addr = '0;
    if (b == 0) return ilha_pkg::ST_NULL;
    need = chunk_bytes(b);
    hit = 0;
    h = (top > ilha_pkg::TAG_BYTES) ? 17'(ilha_pkg::TAG_BYTES) : 17'd0;
    while (h != 0 && !hit) begin
      if (!busy(h) && size_of(h) >= need) hit = 1;
      else h = next_chunk(h);
    end
    if (hit) begin
      carve(h, need);
      mark(h, size_of(h), 1'b1);
    end else begin
      if (top > ilha_pkg::HEAP_BYTES || 32'(need) > ilha_pkg::HEAP_BYTES - 32'(top))
        return ilha_pkg::ST_OOM;
      h = top;
      top = top + need;
      mark(h, need, 1'b1);
    end
    addr = 16'(h + ilha_pkg::TAG_BYTES);
    return ilha_pkg::ST_OK;
  endfunction

  function automatic void heap_free(logic [16:0] p);
    logic [16:0] h;
    logic [16:0] n;
    logic [16:0] pr;
    h = 17'(p - ilha_pkg::TAG_BYTES);
    mark(h, size_of(h), 1'b0);
    n = next_chunk(h);
    if (n != 0 && !busy(n)) mark(h, size_of(h) + size_of(n), 1'b0);
    pr = prev_chunk(h);
    if (pr != 0 && !busy(pr)) mark(pr, size_of(pr) + size_of(h), 1'b0);
  endfunction

  // expected result of one request word; updates the heap image
  function automatic ilha_pkg::rsp_t heap_predict(ilha_pkg::req_t r);
    ilha_pkg::rsp_t o;
    logic [16:0] p;
    logic [16:0] h;
    logic [16:0] old;
    logic [16:0] need;
    logic [16:0] n;
    logic [16:0] op_pay;
    logic [16:0] np_pay;
    logic [15:0] a;
    o = '0;
    o.status = ilha_pkg::ST_NULL;
    p = 17'(r.payload_address);
    if (p < ilha_pkg::MIN_CHUNK || p + ilha_pkg::TAG_BYTES > top) p = '0;
    case (r.operation)
      ilha_pkg::OP_ALLOC: begin
        o.status = heap_alloc(r.request_bytes, a);
        o.result_address = a;
      end
      ilha_pkg::OP_RELEASE: begin
        if (p != 0) heap_free(p);
      end
      ilha_pkg::OP_RESIZE: begin
        if (p == 0) begin
          o.status = heap_alloc(r.request_bytes, a);
          o.result_address = a;
        end else if (r.request_bytes == 0) begin
          heap_free(p);
        end else begin
          h = 17'(p - ilha_pkg::TAG_BYTES);
          old = size_of(h);
          need = chunk_bytes(r.request_bytes);
          n = next_chunk(h);
          if (old >= need) begin
            carve(h, need);
            o.result_address = 16'(p);
            o.status = ilha_pkg::ST_OK;
          end else if (n != 0 && !busy(n) && old + size_of(n) >= need) begin
            mark(h, old + size_of(n), 1'b1);
            carve(h, need);
            mark(h, size_of(h), 1'b1);
            o.result_address = 16'(p);
            o.status = ilha_pkg::ST_OK;
          end else begin
            o.status = heap_alloc(r.request_bytes, a);
            o.result_address = a;
            if (o.status == ilha_pkg::ST_OK) begin
              op_pay = (old >= ilha_pkg::MIN_CHUNK) ? 17'(old - ilha_pkg::MIN_CHUNK) : 17'd0;
              np_pay = 17'(need - ilha_pkg::MIN_CHUNK);
              o.copy_source = 16'(p);
              o.copy_bytes = 16'((op_pay < np_pay) ? op_pay : np_pay);
              heap_free(p);
            end else begin
              o.result_address = '0;
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(0, 3);
  endfunction

  // sizes: mostly small, sometimes large
  function automatic logic [15:0] pick_bytes();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'($urandom_range(1, 4096));
      default: return 16'($urandom_range(1, 200));
    endcase
  endfunction

  // live pointers tracked by the generator, updated as results are predicted
  function automatic void track(ilha_pkg::req_t r, ilha_pkg::rsp_t o);
    int i;
    if (r.operation != ilha_pkg::OP_ALLOC) begin
      for (i = 0; i < live.size(); i++)
        if (live[i] == r.payload_address && r.payload_address != 0) begin
          live.delete(i);
          break;
        end
    end
    if (o.status == ilha_pkg::ST_OK && o.result_address != 0) live.push_back(o.result_address);
  endfunction

  // only valid pointers or zero/invalid below 16 are issued, so no stale reads
  function automatic ilha_pkg::req_t make_req();
    ilha_pkg::req_t r;
    int k;
    k = $urandom_range(0, 99);
    r.request_bytes = pick_bytes();
    r.payload_address = 16'($urandom_range(0, 15));
    if (k < 40 || live.size() == 0) begin
      r.operation = ilha_pkg::OP_ALLOC;
      if ($urandom_range(0, 30) == 0) r.request_bytes = 0;
    end else if (k < 70) begin
      r.operation = ilha_pkg::OP_RELEASE;
      r.payload_address = live[$urandom_range(0, live.size() - 1)];
    end else if (k < 95) begin
      r.operation = ilha_pkg::OP_RESIZE;
      r.payload_address = live[$urandom_range(0, live.size() - 1)];
      if ($urandom_range(0, 20) == 0) r.request_bytes = 0;
    end else begin
      r.operation = 2'($urandom_range(0, 3));
      if (r.operation != ilha_pkg::OP_ALLOC) r.payload_address = 16'($urandom_range(0, 15));
    end
    return r;
  endfunction

  function automatic void queue_req(ilha_pkg::req_t r);
    ilha_pkg::rsp_t o;
    o = heap_predict(r);
    track(r, o);
    pending.push_back(r);
    expected.push_back(o);
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // request word taken at the last rising edge
  always @(posedge clk) begin
    req_taken <= req_valid && !req_stall;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req <= '0;
      req_gap = 0;
    end else if (!req_valid || req_taken) begin
      if (req_valid) void'(pending.pop_front());
      if (req_gap > 0) begin
        req_gap--;
        req_valid <= 1'b0;
      end else if (pending.size() > 0) begin
        req_valid <= 1'b1;
        req <= pending[0];
        req_gap = pick_gap();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      rsp_gap = 0;
    end else if (rsp_gap > 0) begin
      rsp_gap--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
      rsp_gap = pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    ilha_pkg::rsp_t e;
    if (!rst) begin
      idle_cycles <= ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) ?
          0 : idle_cycles + 1;
      if (rsp_valid && !rsp_stall) begin
        if (expected.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %h", rsp);
        end else begin
          e = expected.pop_front();
          if (rsp.result_address !== e.result_address || rsp.status !== e.status ||
              rsp.copy_source !== e.copy_source || rsp.copy_bytes !== e.copy_bytes) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected addr %h st %0d src %h len %h, got %h %0d %h %h",
                       e.result_address, e.status, e.copy_source, e.copy_bytes,
                       rsp.result_address, rsp.status, rsp.copy_source, rsp.copy_bytes);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles > 100000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    ilha_pkg::req_t r;
    int i;
    rst = 1;
    for (i = 0; i < ilha_pkg::TAG_DEPTH; i++) tags[i] = '0;
    top = 17'(ilha_pkg::TAG_BYTES);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: zero size, odd ops, invalid pointers, extremes, oom
    queue_req('{ilha_pkg::OP_ALLOC, 16'd0, 16'd0});
    queue_req('{2'd3, 16'hFFFF, 16'hFFFF});
    queue_req('{ilha_pkg::OP_RELEASE, 16'd0, 16'd0});
    queue_req('{ilha_pkg::OP_RELEASE, 16'hFFFF, 16'd5});
    queue_req('{ilha_pkg::OP_RESIZE, 16'hFFFF, 16'd40});
    queue_req('{ilha_pkg::OP_ALLOC, 16'd0, 16'd1});
    queue_req('{ilha_pkg::OP_ALLOC, 16'd0, 16'd100});
    queue_req('{ilha_pkg::OP_ALLOC, 16'd0, 16'd16});
    queue_req('{ilha_pkg::OP_RESIZE, live[0], 16'd8});
    queue_req('{ilha_pkg::OP_RESIZE, live[0], 16'd300});
    queue_req('{ilha_pkg::OP_RELEASE, live[1], 16'd0});
    queue_req('{ilha_pkg::OP_RESIZE, live[0], 16'd500});
    queue_req('{ilha_pkg::OP_ALLOC, 16'd0, 16'hFFFF});
    queue_req('{ilha_pkg::OP_ALLOC, 16'd0, 16'd60000});
    queue_req('{ilha_pkg::OP_ALLOC, 16'd0, 16'd30000});
    queue_req('{ilha_pkg::OP_RESIZE, live[0], 16'd0});
    queue_req('{ilha_pkg::OP_ALLOC, 16'd0, 16'd48});
    while (live.size() > 0) queue_req('{ilha_pkg::OP_RELEASE, live[0], 16'hFFFF});
    queue_req('{ilha_pkg::OP_ALLOC, 16'd0, 16'd200});

    // pause until the block drains
    wait (pending.size() == 0 && expected.size() == 0);
    repeat (10) @(posedge clk);

    for (i = 0; i < 1950; i++) begin
      // keep heap bounded: flush live pointers now and then
      if (live.size() > 40 && $urandom_range(0, 3) == 0) begin
        r.operation = ilha_pkg::OP_RELEASE;
        r.payload_address = live[$urandom_range(0, live.size() - 1)];
        r.request_bytes = 16'($urandom);
      end else begin
        r = make_req();
      end
      queue_req(r);
      if (pending.size() > 20) wait (pending.size() < 10);
    end
    wait (pending.size() == 0 && expected.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
